>>> design/rcfca_pkg.sv
`timescale 1ns / 1ps
package rcfca_pkg;

  typedef enum logic [2:0] {
    ARM_WAIT_LOW   = 3'd0,
    ARM_WAIT_HIGH  = 3'd1,
    ARM_WAIT_LOW2  = 3'd2,
    ARM_ARMING     = 3'd3,
    ARM_ARMED      = 3'd4,
    ARM_LOCKING    = 3'd5
  } rcfca_arm_state_e;

  typedef enum logic [1:0] {
    LED_NONE  = 2'd0,
    LED_ON    = 2'd1,
    LED_FLASH = 2'd2
  } rcfca_led_e;

  typedef enum logic [2:0] {
    REG_LOSS_LIMIT  = 3'd0,
    REG_IDLE_LOCK   = 3'd1,
    REG_HIGH_HOLD   = 3'd2,
    REG_TILT_GAIN   = 3'd3,
    REG_YAW_STEP    = 3'd4,
    REG_YAW_HIGH    = 3'd5,
    REG_YAW_LOW     = 3'd6,
    REG_NONE        = 3'd7
  } rcfca_reg_e;

  localparam logic [7:0]  HDR_BYTE0 = 8'hAA;
  localparam logic [7:0]  HDR_BYTE1 = 8'hAF;

  localparam logic [10:0] STICK_MIN  = 11'd1000;
  localparam logic [10:0] STICK_MID  = 11'd1500;
  localparam logic [10:0] STICK_MAX  = 11'd2000;
  localparam logic [10:0] CORNER_THR = 11'd1050;
  localparam logic [10:0] CORNER_YAW = 11'd1200;
  localparam logic [10:0] WAKE_THR   = 11'd1150;
  localparam logic [10:0] HIGH_THR   = 11'd1600;
  localparam logic [10:0] LOW2_THR   = 11'd1100;
  localparam logic [10:0] IDLE_THR   = 11'd1020;
  localparam logic [11:0] IDLE_MAX   = 12'd4095;

  localparam logic [9:0]  LOSS_LIMIT_RST = 10'd500;
  localparam logic [11:0] IDLE_LOCK_RST  = 12'd3000;
  localparam logic [7:0]  HIGH_HOLD_RST  = 8'd5;
  localparam logic [7:0]  TILT_GAIN_RST  = 8'd4;
  localparam logic [9:0]  YAW_STEP_RST   = 10'd30;
  localparam logic [10:0] YAW_HIGH_RST   = 11'd1820;
  localparam logic [10:0] YAW_LOW_RST    = 11'd1180;

  typedef struct packed {
    logic        step;
    logic        disarm;
    logic [10:0] thr;
    logic [10:0] yaw;
  } rcfca_arm_req_t;

  typedef struct packed {
    logic             unlocked;
    rcfca_arm_state_e state;
    rcfca_led_e       led;
    logic             imu;
  } rcfca_arm_rsp_t;

  function automatic logic [10:0] clamp_stick(input logic [15:0] v);
    logic [10:0] r;
    if (v < 16'(STICK_MIN)) begin
      r = STICK_MIN;
    end else if (v > 16'(STICK_MAX)) begin
      r = STICK_MAX;
    end else begin
      r = v[10:0];
    end
    return r;
  endfunction

endpackage

>>> design/rcfca_in_if.sv
`timescale 1ns / 1ps
interface rcfca_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;

  modport source (output valid, output action, output data_byte, input ready);
  modport sink (input valid, input action, input data_byte, output ready);
endinterface

>>> design/rcfca_out_if.sv
`timescale 1ns / 1ps
interface rcfca_out_if;
  logic               valid;
  logic               ready;
  logic               frame_valid;
  logic               radio_reinit;
  logic               armed;
  logic [2:0]         arm_state;
  logic               imu_reset;
  logic [1:0]         led_command;
  logic [10:0]        throttle;
  logic [10:0]        yaw_stick;
  logic signed [17:0] pitch_target;
  logic signed [17:0] roll_target;
  logic signed [23:0] yaw_target;

  modport source (
    output valid, input ready,
    output frame_valid, output radio_reinit, output armed, output arm_state,
    output imu_reset, output led_command, output throttle, output yaw_stick,
    output pitch_target, output roll_target, output yaw_target
  );
  modport sink (
    input valid, output ready,
    input frame_valid, input radio_reinit, input armed, input arm_state,
    input imu_reset, input led_command, input throttle, input yaw_stick,
    input pitch_target, input roll_target, input yaw_target
  );
endinterface

>>> design/rcfca_arm_seq.sv
`timescale 1ns / 1ps
module rcfca_arm_seq (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  rcfca_pkg::rcfca_arm_req_t req_i,
  input  logic [11:0]             idle_lock_limit_i,
  input  logic [7:0]              high_hold_frames_i,
  output rcfca_pkg::rcfca_arm_rsp_t rsp_o
);

  rcfca_pkg::rcfca_arm_state_e seq_q, seq_d, st_eff;
  logic [7:0]  hold_q, hold_d;
  logic [11:0] idle_q, idle_d;
  logic        unlocked_q, unlocked_d;
  rcfca_pkg::rcfca_led_e led;
  logic        imu;

  // stick corner forces the locking state before the sequence step
  always_comb begin
    if (req_i.thr < rcfca_pkg::CORNER_THR && req_i.yaw < rcfca_pkg::CORNER_YAW) begin
      st_eff = rcfca_pkg::ARM_LOCKING;
    end else begin
      st_eff = seq_q;
    end
  end

  // next state
  always_comb begin
    seq_d = seq_q;
    if (req_i.step) begin
      case (st_eff)
        rcfca_pkg::ARM_WAIT_LOW: begin
          if (req_i.thr < rcfca_pkg::WAKE_THR) seq_d = rcfca_pkg::ARM_WAIT_HIGH;
        end
        rcfca_pkg::ARM_WAIT_HIGH: begin
          if (req_i.thr > rcfca_pkg::HIGH_THR && hold_q >= high_hold_frames_i) begin
            seq_d = rcfca_pkg::ARM_WAIT_LOW2;
          end
        end
        rcfca_pkg::ARM_WAIT_LOW2: begin
          if (req_i.thr < rcfca_pkg::LOW2_THR) seq_d = rcfca_pkg::ARM_ARMING;
        end
        rcfca_pkg::ARM_ARMING: begin
          seq_d = rcfca_pkg::ARM_ARMED;
        end
        rcfca_pkg::ARM_ARMED: begin
          if (req_i.thr < rcfca_pkg::IDLE_THR) begin
            if (idle_q > idle_lock_limit_i) seq_d = rcfca_pkg::ARM_LOCKING;
          end else if (!unlocked_q) begin
            seq_d = rcfca_pkg::ARM_LOCKING;
          end
        end
        rcfca_pkg::ARM_LOCKING: begin
          seq_d = rcfca_pkg::ARM_WAIT_LOW;
        end
        default: begin
          seq_d = rcfca_pkg::ARM_LOCKING;
        end
      endcase
    end
  end

  // counters, unlock flag and pulses
  always_comb begin
    hold_d     = hold_q;
    idle_d     = idle_q;
    unlocked_d = unlocked_q;
    led        = rcfca_pkg::LED_NONE;
    imu        = 1'b0;
    if (req_i.disarm) begin
      unlocked_d = 1'b0;
    end else if (req_i.step) begin
      case (st_eff)
        rcfca_pkg::ARM_WAIT_HIGH: begin
          if (req_i.thr > rcfca_pkg::HIGH_THR) begin
            if (hold_q >= high_hold_frames_i) begin
              hold_d = '0;
            end else begin
              hold_d = hold_q + 8'd1;
            end
          end
        end
        rcfca_pkg::ARM_ARMING: begin
          unlocked_d = 1'b1;
          led        = rcfca_pkg::LED_ON;
          imu        = 1'b1;
        end
        rcfca_pkg::ARM_ARMED: begin
          if (req_i.thr < rcfca_pkg::IDLE_THR) begin
            if (idle_q < rcfca_pkg::IDLE_MAX) idle_d = idle_q + 12'd1;
          end else if (unlocked_q) begin
            idle_d = '0;
          end
        end
        rcfca_pkg::ARM_LOCKING: begin
          led        = rcfca_pkg::LED_FLASH;
          idle_d     = '0;
          unlocked_d = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q      <= rcfca_pkg::ARM_WAIT_LOW;
      hold_q     <= '0;
      idle_q     <= '0;
      unlocked_q <= 1'b0;
    end else begin
      seq_q      <= seq_d;
      hold_q     <= hold_d;
      idle_q     <= idle_d;
      unlocked_q <= unlocked_d;
    end
  end

  assign rsp_o.unlocked = unlocked_d;
  assign rsp_o.state    = seq_d;
  assign rsp_o.led      = led;
  assign rsp_o.imu      = imu;

endmodule

>>> design/rc_frame_check_and_arming.sv
`timescale 1ns / 1ps
// radio control frame checker and arming sequencer
// in_i carries one transfer per frame byte (action 0) or per empty poll
// (action 1). bytes of a frame come in order; the last byte of a frame and
// every poll each produce one result transfer on out_o, other bytes none.
// a poll in the middle of a frame drops the partial frame.
// the result is in the output register in the cycle after the input
// transfer. throughput: one input transfer per cycle unless out_o stalls,
// since all the work for a transfer is done in the cycle it is accepted.
// when the receiver stalls the result waits in the output register and
// in_i.ready stays low until that result is taken; a result taken in the
// same cycle frees the register for the next input transfer.
// the apb port writes the limits, gain, yaw step and thresholds at 4*index
// and reads them back; writes are meant for an idle block.
// after reset the config registers take their documented defaults, the
// sequencer waits for low throttle and no result is pending.
module rc_frame_check_and_arming #(
  parameter int FRAME_BYTES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rcfca_in_if.sink    in_i,
  rcfca_out_if.source out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int BW = $clog2(FRAME_BYTES);
  localparam logic [BW-1:0] LastPos  = BW'(FRAME_BYTES - 1);
  localparam logic [BW-1:0] ChanLo   = BW'(4);
  localparam logic [BW-1:0] ChanHi   = BW'(11);

  // configuration
  logic [9:0]  loss_limit_q;
  logic [11:0] idle_lock_q;
  logic [7:0]  high_hold_q;
  logic [7:0]  tilt_gain_q;
  logic [9:0]  yaw_step_q;
  logic [10:0] yaw_high_q;
  logic [10:0] yaw_low_q;
  logic        cfg_wr;
  rcfca_pkg::rcfca_reg_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = rcfca_pkg::rcfca_reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loss_limit_q <= rcfca_pkg::LOSS_LIMIT_RST;
      idle_lock_q  <= rcfca_pkg::IDLE_LOCK_RST;
      high_hold_q  <= rcfca_pkg::HIGH_HOLD_RST;
      tilt_gain_q  <= rcfca_pkg::TILT_GAIN_RST;
      yaw_step_q   <= rcfca_pkg::YAW_STEP_RST;
      yaw_high_q   <= rcfca_pkg::YAW_HIGH_RST;
      yaw_low_q    <= rcfca_pkg::YAW_LOW_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        rcfca_pkg::REG_LOSS_LIMIT: loss_limit_q <= pwdata[9:0];
        rcfca_pkg::REG_IDLE_LOCK:  idle_lock_q  <= pwdata[11:0];
        rcfca_pkg::REG_HIGH_HOLD:  high_hold_q  <= pwdata[7:0];
        rcfca_pkg::REG_TILT_GAIN:  tilt_gain_q  <= pwdata[7:0];
        rcfca_pkg::REG_YAW_STEP:   yaw_step_q   <= pwdata[9:0];
        rcfca_pkg::REG_YAW_HIGH:   yaw_high_q   <= pwdata[10:0];
        rcfca_pkg::REG_YAW_LOW:    yaw_low_q    <= pwdata[10:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      rcfca_pkg::REG_LOSS_LIMIT: prdata = 32'(loss_limit_q);
      rcfca_pkg::REG_IDLE_LOCK:  prdata = 32'(idle_lock_q);
      rcfca_pkg::REG_HIGH_HOLD:  prdata = 32'(high_hold_q);
      rcfca_pkg::REG_TILT_GAIN:  prdata = 32'(tilt_gain_q);
      rcfca_pkg::REG_YAW_STEP:   prdata = 32'(yaw_step_q);
      rcfca_pkg::REG_YAW_HIGH:   prdata = 32'(yaw_high_q);
      rcfca_pkg::REG_YAW_LOW:    prdata = 32'(yaw_low_q);
      default:                   prdata = '0;
    endcase
  end

  // frame state
  logic [BW-1:0] pos_q, pos_d;
  logic [7:0]    sum_q, sum_d;
  logic          hdr_q, hdr_d;
  logic [7:0]    ch_q [8];
  logic [2:0]    ch_idx;
  logic          ch_we;
  logic [BW-1:0] ch_off;
  logic signed [23:0] acc_q, acc_d;
  logic [9:0]    loss_q, loss_d;
  logic [10:0]   thr_q, thr_d, yaw_q, yaw_d;

  // output register
  logic               out_valid_q, out_valid_d;
  logic               o_fv_q, o_reinit_q, o_armed_q, o_imu_q;
  logic [2:0]         o_state_q;
  logic [1:0]         o_led_q;
  logic [10:0]        o_thr_q, o_yaw_q;
  logic signed [17:0] o_pitch_q, o_roll_q, pitch_res, roll_res;
  logic signed [23:0] o_acc_q;

  logic accept, at_last, frame_done, poll, produce, frame_ok, good_frame, reinit;
  logic [10:0] roll_c, pitch_c, thr_c, yaw_c;
  logic signed [11:0] pitch_diff, roll_diff;
  logic signed [8:0]  gain_s;
  logic signed [20:0] pitch_prod, roll_prod;
  logic signed [24:0] acc_ext, step_ext, acc_dec, acc_inc;
  logic signed [23:0] dec_sat, inc_sat;

  rcfca_pkg::rcfca_arm_req_t arm_req;
  rcfca_pkg::rcfca_arm_rsp_t arm_rsp;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign at_last    = pos_q == LastPos;
  assign poll       = accept && in_i.action;
  assign frame_done = accept && !in_i.action && at_last;
  assign produce    = poll || frame_done;
  assign frame_ok   = hdr_q && (in_i.data_byte == sum_q);
  assign good_frame = frame_done && frame_ok;
  assign reinit     = poll && (loss_q >= loss_limit_q);

  // big-endian channels
  assign roll_c  = rcfca_pkg::clamp_stick({ch_q[0], ch_q[1]});
  assign pitch_c = rcfca_pkg::clamp_stick({ch_q[2], ch_q[3]});
  assign thr_c   = rcfca_pkg::clamp_stick({ch_q[4], ch_q[5]});
  assign yaw_c   = rcfca_pkg::clamp_stick({ch_q[6], ch_q[7]});

  assign gain_s     = $signed({1'b0, tilt_gain_q});
  assign pitch_diff = $signed({1'b0, rcfca_pkg::STICK_MID}) - $signed({1'b0, pitch_c});
  assign roll_diff  = $signed({1'b0, rcfca_pkg::STICK_MID}) - $signed({1'b0, roll_c});
  assign pitch_prod = pitch_diff * gain_s;
  assign roll_prod  = roll_diff * gain_s;
  assign pitch_res  = good_frame ? pitch_prod[17:0] : '0;
  assign roll_res   = good_frame ? roll_prod[17:0] : '0;

  // saturating yaw accumulator
  assign acc_ext  = {acc_q[23], acc_q};
  assign step_ext = $signed({15'd0, yaw_step_q});
  assign acc_dec  = acc_ext - step_ext;
  assign acc_inc  = acc_ext + step_ext;
  assign dec_sat  = (acc_dec[24:23] == 2'b10) ? {1'b1, 23'd0} : acc_dec[23:0];
  assign inc_sat  = (acc_inc[24:23] == 2'b01) ? {1'b0, {23{1'b1}}} : acc_inc[23:0];

  always_comb begin
    acc_d = acc_q;
    thr_d = thr_q;
    yaw_d = yaw_q;
    if (good_frame) begin
      thr_d = thr_c;
      yaw_d = yaw_c;
      if (yaw_c > yaw_high_q) begin
        acc_d = dec_sat;
      end else if (yaw_c < yaw_low_q) begin
        acc_d = inc_sat;
      end
    end
  end

  always_comb begin
    loss_d = loss_q;
    if (poll) begin
      loss_d = reinit ? '0 : loss_q + 10'd1;
    end else if (frame_done) begin
      loss_d = '0;
    end
  end

  assign ch_off = pos_q - ChanLo;
  assign ch_idx = ch_off[2:0];
  assign ch_we  = accept && !in_i.action && !at_last && pos_q >= ChanLo && pos_q <= ChanHi;

  always_comb begin
    pos_d = pos_q;
    sum_d = sum_q;
    hdr_d = hdr_q;
    if (accept) begin
      if (in_i.action || at_last) begin
        pos_d = '0;
        sum_d = '0;
        hdr_d = 1'b0;
      end else begin
        pos_d = pos_q + BW'(1);
        sum_d = sum_q + in_i.data_byte;
        if (pos_q == '0) begin
          hdr_d = in_i.data_byte == rcfca_pkg::HDR_BYTE0;
        end else if (pos_q == BW'(1)) begin
          hdr_d = hdr_q && (in_i.data_byte == rcfca_pkg::HDR_BYTE1);
        end
      end
    end
  end

  assign arm_req.step   = good_frame;
  assign arm_req.disarm = reinit;
  assign arm_req.thr    = thr_c;
  assign arm_req.yaw    = yaw_c;

  rcfca_arm_seq u_arm_seq (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .req_i              (arm_req),
    .idle_lock_limit_i  (idle_lock_q),
    .high_hold_frames_i (high_hold_q),
    .rsp_o              (arm_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      sum_q  <= '0;
      hdr_q  <= 1'b0;
      acc_q  <= '0;
      loss_q <= '0;
      thr_q  <= rcfca_pkg::STICK_MIN;
      yaw_q  <= rcfca_pkg::STICK_MID;
    end else begin
      pos_q  <= pos_d;
      sum_q  <= sum_d;
      hdr_q  <= hdr_d;
      acc_q  <= acc_d;
      loss_q <= loss_d;
      thr_q  <= thr_d;
      yaw_q  <= yaw_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ch_we) ch_q[ch_idx] <= in_i.data_byte;
  end

  always_comb begin
    if (produce) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (produce) begin
      o_fv_q     <= good_frame;
      o_reinit_q <= reinit;
      o_armed_q  <= arm_rsp.unlocked;
      o_state_q  <= arm_rsp.state;
      o_imu_q    <= arm_rsp.imu;
      o_led_q    <= arm_rsp.led;
      o_thr_q    <= thr_d;
      o_yaw_q    <= yaw_d;
      o_pitch_q  <= pitch_res;
      o_roll_q   <= roll_res;
      o_acc_q    <= acc_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.frame_valid  = o_fv_q;
  assign out_o.radio_reinit = o_reinit_q;
  assign out_o.armed        = o_armed_q;
  assign out_o.arm_state    = o_state_q;
  assign out_o.imu_reset    = o_imu_q;
  assign out_o.led_command  = o_led_q;
  assign out_o.throttle     = o_thr_q;
  assign out_o.yaw_stick    = o_yaw_q;
  assign out_o.pitch_target = o_pitch_q;
  assign out_o.roll_target  = o_roll_q;
  assign out_o.yaw_target   = o_acc_q;

endmodule
